// ----- src/cssc_pkg.sv -----
// ----------------------------------------------------------------------------
// cssc_pkg
// Shared types and constants for the comment strip / space collapse block.
// ----------------------------------------------------------------------------
package cssc_pkg;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Scanner state
  typedef enum logic [2:0] {
    MODE_SKIP  = 3'd0,  // dropping spaces (start of text, after a comment)
    MODE_SPACE = 3'd1,  // one space just passed
    MODE_SLASH = 3'd2,  // a slash is held
    MODE_TEXT  = 3'd3,  // ordinary text
    MODE_LINE  = 3'd4,  // inside a line comment
    MODE_BLOCK = 3'd5,  // inside a block comment
    MODE_STAR  = 3'd6   // inside a block comment, last byte a star
  } scan_mode_t;

  // One queued work entry: a byte, optionally preceded by a held slash
  typedef struct packed {
    logic       two;    // emit a slash before data
    logic [7:0] data;
  } cssc_entry_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } cssc_qstat_t;

endpackage

// ----- src/comment_strip_space_collapse.sv -----
// Path: an input transfer writes the queue; the output register then loads from
//   the queue head whenever it is empty or its result is being taken.
// Throughput: one input per cycle while the queue has room; the back gives one
//   result per cycle while out_stall is low, and a two-result input holds it until
//   both are out. The four-entry queue absorbs bursts; long pair runs stall the input.
// Reset: synchronous active-low rst_n clears scanner mode, queue and output.
// ----------------------------------------------------------------------------
// comment_strip_space_collapse
// Removes line and block comments from a byte stream and collapses runs of
// whitespace into single spaces.
// ----------------------------------------------------------------------------
module comment_strip_space_collapse (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_kept_byte,
  output logic       out_last_of_run
);
  import cssc_pkg::*;

  logic        push;
  logic        pop;
  cssc_entry_t push_entry;
  cssc_entry_t head;
  cssc_qstat_t qstat;

  // Scanner
  cssc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_end_of_text(in_end_of_text),
    .qstat         (qstat),
    .push          (push),
    .push_entry    (push_entry)
  );

  // Work queue
  cssc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Output stage
  cssc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kept_byte  (out_kept_byte),
    .out_last_of_run(out_last_of_run)
  );

endmodule

// ----- src/cssc_front.sv -----
// ----------------------------------------------------------------------------
// cssc_front
// Accepts source bytes, runs the scanner state machine and pushes the
// resulting output work into the queue.
// ----------------------------------------------------------------------------
module cssc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_end_of_text,
  input  cssc_pkg::cssc_qstat_t qstat,
  output logic                 push,
  output cssc_pkg::cssc_entry_t push_entry
);
  import cssc_pkg::*;

  scan_mode_t  mode_r;
  scan_mode_t  mode_nxt;
  scan_mode_t  mode_step;
  logic [7:0]  c;
  logic        accept;
  logic        emit;
  cssc_entry_t entry;

  // Stall only on a full queue
  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  // Map whitespace to a plain space
  always_comb begin
    if (in_text_byte == CH_TAB || in_text_byte == CH_LF || in_text_byte == CH_CR) begin
      c = CH_SPACE;
    end else begin
      c = in_text_byte;
    end
  end

  // Classify the byte against the current mode
  always_comb begin
    mode_step  = mode_r;
    emit       = 1'b0;
    entry.two  = 1'b0;
    entry.data = c;
    case (mode_r)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_step = MODE_LINE;
        end else if (c == CH_STAR) begin
          mode_step = MODE_BLOCK;
        end else begin
          emit      = 1'b1;
          entry.two = 1'b1;
          mode_step = (c == CH_SPACE) ? MODE_SPACE : MODE_TEXT;
        end
      end
      MODE_TEXT: begin
        if (c == CH_SPACE) begin
          mode_step = MODE_SPACE;
          emit      = 1'b1;
        end else if (c == CH_SLASH) begin
          mode_step = MODE_SLASH;
        end else begin
          emit = 1'b1;
        end
      end
      MODE_LINE: begin
        if (in_text_byte == CH_LF) begin
          mode_step = MODE_SKIP;
        end
      end
      MODE_BLOCK: begin
        if (in_text_byte == CH_STAR) begin
          mode_step = MODE_STAR;
        end
      end
      MODE_STAR: begin
        if (in_text_byte == CH_SLASH) begin
          mode_step = MODE_SKIP;
        end else if (in_text_byte != CH_STAR) begin
          mode_step = MODE_BLOCK;
        end
      end
      default: begin
        // skip, one space passed, and the unused code
        if (c == CH_SPACE) begin
          mode_step = MODE_SKIP;
        end else if (c == CH_SLASH) begin
          mode_step = MODE_SLASH;
        end else begin
          mode_step = MODE_TEXT;
          emit      = 1'b1;
        end
      end
    endcase

    // End of text: flush a held slash, restart scanning
    mode_nxt = mode_step;
    if (in_end_of_text) begin
      if (mode_step == MODE_SLASH) begin
        emit       = 1'b1;
        entry.two  = 1'b0;
        entry.data = CH_SLASH;
      end
      mode_nxt = MODE_SKIP;
    end
  end

  assign push       = accept && emit;
  assign push_entry = entry;

  // Advance the scanner on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SKIP;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ----- src/cssc_fifo.sv -----
// ----------------------------------------------------------------------------
// cssc_fifo
// Short register queue of work entries between the front and the back.
// ----------------------------------------------------------------------------
module cssc_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cssc_pkg::cssc_entry_t push_entry,
  input  logic                  pop,
  output cssc_pkg::cssc_entry_t head,
  output cssc_pkg::cssc_qstat_t qstat
);
  import cssc_pkg::*;

  cssc_entry_t        mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r;
  logic [FIFO_CW-1:0] count_nxt;

  assign qstat.full  = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth and track the entry count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Hold pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- src/cssc_back.sv -----
// ----------------------------------------------------------------------------
// cssc_back
// Drains queued entries into the output register, splitting an entry with a
// held slash into two results.
// ----------------------------------------------------------------------------
module cssc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cssc_pkg::cssc_entry_t head,
  input  cssc_pkg::cssc_qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_kept_byte,
  output logic                  out_last_of_run
);
  import cssc_pkg::*;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       last_r;
  logic       last_nxt;
  logic       phase_r;
  logic       phase_nxt;
  logic       load;

  // Refill the output register when empty or being taken
  assign load = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    if (load) begin
      if (!qstat.empty) begin
        out_valid_nxt = 1'b1;
        if (head.two && !phase_r) begin
          // release the held slash first, keep the entry
          byte_nxt  = CH_SLASH;
          last_nxt  = 1'b0;
          phase_nxt = 1'b1;
        end else begin
          byte_nxt  = head.data;
          last_nxt  = 1'b1;
          phase_nxt = 1'b0;
          pop       = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kept_byte   = byte_r;
  assign out_last_of_run = last_r;

  a_first_is_slash: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> (byte_r == CH_SLASH))
    else $error("non-final result is not a slash");

  a_phase_matches: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (out_valid_r && !last_r && !qstat.empty && head.two))
    else $error("split phase without pending pair");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !last_r) |=> (out_valid_r && last_r))
    else $error("second half of pair missing");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for comment_strip_space_collapse. Sends whole texts built from
// words, whitespace runs, line and block comments and stray slashes. Runs
// under four traffic patterns: no gaps, sparse input, heavy output stall,
// and light gaps with light stall. A scoreboard follows the scanner state, builds the
// cleaned characters each accepted byte should release, and checks every
// output transfer against them in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cssc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Tracks scanner mode and the cleaned characters still owed by the block
  class clean_text_scoreboard;
    typedef struct packed {
      logic [7:0] kept;
      logic       last;
    } clean_char_t;

    scan_mode_t  mode;
    clean_char_t owed_chars[$];
    int          mismatches;

    function new();
      mode       = MODE_SKIP;
      mismatches = 0;
    endfunction

    // Advance the scanner by one accepted byte and queue what it releases
    function void note_byte(logic [7:0] raw, logic eot);
      logic [7:0] c;
      logic [7:0] released[$];
      clean_char_t entry;
      c = (raw == CH_TAB || raw == CH_LF || raw == CH_CR) ? CH_SPACE : raw;
      case (mode)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode = MODE_LINE;
          end else if (c == CH_STAR) begin
            mode = MODE_BLOCK;
          end else begin
            released.push_back(CH_SLASH);
            released.push_back(c);
            mode = (c == CH_SPACE) ? MODE_SPACE : MODE_TEXT;
          end
        end
        MODE_TEXT: begin
          if (c == CH_SPACE) begin
            mode = MODE_SPACE;
            released.push_back(c);
          end else if (c == CH_SLASH) begin
            mode = MODE_SLASH;
          end else begin
            released.push_back(c);
          end
        end
        MODE_LINE: begin
          // only a raw newline ends a line comment
          if (raw == CH_LF) mode = MODE_SKIP;
        end
        MODE_BLOCK: begin
          if (raw == CH_STAR) mode = MODE_STAR;
        end
        MODE_STAR: begin
          if (raw == CH_SLASH) mode = MODE_SKIP;
          else if (raw != CH_STAR) mode = MODE_BLOCK;
        end
        default: begin
          // skipping spaces and just-after-space behave alike
          if (c == CH_SPACE) begin
            mode = MODE_SKIP;
          end else if (c == CH_SLASH) begin
            mode = MODE_SLASH;
          end else begin
            mode = MODE_TEXT;
            released.push_back(c);
          end
        end
      endcase
      // end of text flushes a held slash and restarts the scanner
      if (eot) begin
        if (mode == MODE_SLASH) released.push_back(CH_SLASH);
        mode = MODE_SKIP;
      end
      foreach (released[i]) begin
        entry.kept = released[i];
        entry.last = (i == released.size() - 1);
        owed_chars.push_back(entry);
      end
    endfunction

    // Compare one output transfer with the oldest owed character
    function void check_char(logic [7:0] kept, logic last);
      clean_char_t exp_char;
      if (owed_chars.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kept_byte %02h last_of_run %0b",
                 $time, kept, last);
        mismatches++;
      end else begin
        exp_char = owed_chars.pop_front();
        if (kept !== exp_char.kept) begin
          $display("%0t: kept_byte mismatch, expected %02h, got %02h",
                   $time, exp_char.kept, kept);
          mismatches++;
        end
        if (last !== exp_char.last) begin
          $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                   $time, exp_char.last, last);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return owed_chars.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_kept_byte;
  logic       out_last_of_run;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;

  clean_text_scoreboard sb;

  comment_strip_space_collapse i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kept_byte  (out_kept_byte),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Random output backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watch both channels for transfers
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_byte(in_text_byte, in_end_of_text);
    if (rst_n && out_valid && !out_stall) sb.check_char(out_kept_byte, out_last_of_run);
  end

  // Traffic pattern: 0 none, 1 sparse input, 2 heavy stall, 3 light both
  function automatic void set_phase(int phase);
    case (phase)
      1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
      3:       begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  // Build one random text from comment, word and whitespace pieces
  function automatic byte_q_t build_text();
    byte_q_t    txt;
    int         target;
    int         kind;
    int         len;
    logic [7:0] b;
    target = $urandom_range(3, 40);
    while (txt.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // word of printable characters
        len = $urandom_range(1, 6);
        repeat (len) txt.push_back(8'($urandom_range(33, 126)));
      end else if (kind < 55) begin
        // whitespace run
        len = $urandom_range(1, 3);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       b = CH_SPACE;
            1:       b = CH_TAB;
            2:       b = CH_LF;
            default: b = CH_CR;
          endcase
          txt.push_back(b);
        end
      end else if (kind < 65) begin
        // line comment, mostly closed by a newline
        txt.push_back(CH_SLASH);
        txt.push_back(CH_SLASH);
        len = $urandom_range(0, 8);
        repeat (len) txt.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0) txt.push_back(CH_LF);
      end else if (kind < 77) begin
        // block comment with stars and slashes inside, mostly closed
        txt.push_back(CH_SLASH);
        txt.push_back(CH_STAR);
        len = $urandom_range(0, 8);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       b = CH_STAR;
            1:       b = CH_SLASH;
            2:       b = 8'($urandom_range(0, 255));
            default: b = 8'($urandom_range(97, 122));
          endcase
          txt.push_back(b);
        end
        if ($urandom_range(0, 9) != 0) begin
          repeat ($urandom_range(1, 3)) txt.push_back(CH_STAR);
          txt.push_back(CH_SLASH);
        end
      end else if (kind < 87) begin
        txt.push_back(CH_SLASH);
      end else begin
        txt.push_back(8'($urandom_range(0, 255)));
      end
    end
    return txt;
  endfunction

  // Offer one byte, with random idle cycles ahead, and hold until transfer
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input byte_q_t txt);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  initial begin
    byte_q_t txt;
    int      text_idx;
    in_valid       <= 1'b0;
    in_text_byte   <= 8'h00;
    in_end_of_text <= 1'b0;
    rst_n          <= 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: leading spaces, byte extremes, whitespace pair, slash then
    // space, slash then letter, line comment past a CR, block comment closed
    // after a star run, unterminated comment at end of text
    set_phase(0);
    txt = {CH_SPACE, CH_TAB, 8'h00, 8'hFF, CH_LF, CH_CR,
           CH_SLASH, CH_SPACE, CH_SLASH, 8'h78,
           CH_SLASH, CH_SLASH, 8'h61, CH_CR, CH_LF,
           CH_SLASH, CH_STAR, CH_STAR, CH_STAR, CH_SLASH, 8'h62,
           CH_SLASH, CH_STAR, 8'h7A};
    send_text(txt);
    // held slash flushed at end of text
    txt = {CH_SLASH};
    send_text(txt);

    // Random texts, rotating the traffic pattern every few texts
    text_idx = 0;
    while (bytes_sent < 1150) begin
      set_phase((text_idx / 5) % 4);
      txt = build_text();
      send_text(txt);
      text_idx++;
    end
    in_valid <= 1'b0;

    // Drain, then allow the pipeline to settle
    set_phase(0);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still owed", $time, sb.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- comment_strip_space_collapse.f -----
src/cssc_pkg.sv
src/cssc_front.sv
src/cssc_fifo.sv
src/cssc_back.sv
src/comment_strip_space_collapse.sv
test/tb_top.sv
